// ----- hw/rtl/cbc_pkg.sv -----
// Shared types, codes and helpers for the cartridge bank controller.
package cbc_pkg;

   localparam int RAM_OFF_W  = 13;
   localparam int RAM_BYTES  = 8192;
   localparam int ROM_OFF_W  = 14;
   localparam int ROM_ADDR_W = 23;
   localparam int PADDR_W    = 5;

   localparam logic [1:0] VER_ROM_ONLY = 2'd0;
   localparam logic [1:0] VER_BANKED   = 2'd1;
   localparam logic [1:0] VER_CLOCK    = 2'd2;
   localparam logic [1:0] VER_WIDE     = 2'd3;

   localparam logic [1:0] SRC_NONE  = 2'd0;
   localparam logic [1:0] SRC_ROM   = 2'd1;
   localparam logic [1:0] SRC_RAM   = 2'd2;
   localparam logic [1:0] SRC_CLOCK = 2'd3;

   localparam logic [2:0] REG_VERSION  = 3'd0;
   localparam logic [2:0] REG_HAS_RAM  = 3'd1;
   localparam logic [2:0] REG_HAS_CLK  = 3'd2;
   localparam logic [2:0] REG_ROM_CNT  = 3'd3;
   localparam logic [2:0] REG_MODE_OK  = 3'd4;

   localparam logic [2:0] CLK_SEC  = 3'd0;
   localparam logic [2:0] CLK_MIN  = 3'd1;
   localparam logic [2:0] CLK_HR   = 3'd2;
   localparam logic [2:0] CLK_DAYL = 3'd3;
   localparam logic [2:0] CLK_DAYH = 3'd4;

   typedef enum logic [2:0] {
      OP_NONE, OP_ENABLE, OP_ROM_BANK, OP_RAM_BANK,
      OP_MODE, OP_RAM_WRITE, OP_ROM_READ, OP_RAM_READ
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [15:0] addr;
      logic [7:0]  data;
      logic [31:0] elapsed;
   } entry_type;

   typedef struct packed {
      logic [1:0] version;
      logic       has_ram;
      logic       has_clock;
      logic [9:0] rom_count;
      logic       mode_ok;
   } cfg_type;

   typedef struct packed {
      logic       done;
      logic [5:0] sec;
      logic [5:0] min;
      logic [4:0] hr;
      logic [8:0] day;
      logic       ovf;
   } clk_upd_type;

   // bank >= count becomes count - 1; a count of zero acts as one
   function automatic logic [8:0] clamp_bank(input logic [8:0] b, input logic [9:0] cnt);
      logic [9:0] c1;
      c1 = (cnt == 10'd0) ? 10'd1 : cnt;
      if ({1'b0, b} >= c1) return 9'(c1 - 10'd1);
      return b;
   endfunction

endpackage

// ----- hw/rtl/cartridge_bank_controller_unit.sv -----
// Top level: config registers, front end, queue and back end of the bank controller.
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | mode, bus_address, write_data, elapsed_seconds
//  rsp     | out       | rsp_valid/rsp_stall  | read_data, data_source, rom_address
//  csr     | in        | psel/penable/pready  | paddr, pwdata, prdata (5 registers at 4*i)
// One word per cycle in and out unless stalled; each word is queued, then registered as a result.
// A clock latch write holds the back end while the clock unit is busy with three reciprocal
// divisions (quotient then remainder state each), then an update; words queue (two-entry queue).
// After reset the RAM (RAM_BANKS*8192 bytes) is cleared one byte a cycle; no result meanwhile.
// rsp_stall holds the result register; the queue keeps accepting until full.
module cartridge_bank_controller_unit #(
   parameter int RAM_BANKS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [15:0] req_bus_address,
   input  logic [7:0]  req_write_data,
   input  logic [31:0] req_elapsed_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic [1:0]  rsp_data_source,
   output logic [22:0] rsp_rom_address,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [cbc_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import cbc_pkg::*;

   cfg_type   cfg_ff;
   entry_type q_entry;
   logic      q_valid, q_pop, wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.version   <= VER_BANKED;
         cfg_ff.has_ram   <= 1'b0;
         cfg_ff.has_clock <= 1'b0;
         cfg_ff.rom_count <= 10'd2;
         cfg_ff.mode_ok   <= 1'b0;
      end else if (wr_en) begin
         case (paddr[4:2])
            REG_VERSION: cfg_ff.version   <= pwdata[1:0];
            REG_HAS_RAM: cfg_ff.has_ram   <= pwdata[0];
            REG_HAS_CLK: cfg_ff.has_clock <= pwdata[0];
            REG_ROM_CNT: cfg_ff.rom_count <= pwdata[9:0];
            REG_MODE_OK: cfg_ff.mode_ok   <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_VERSION: prdata = {30'd0, cfg_ff.version};
         REG_HAS_RAM: prdata = {31'd0, cfg_ff.has_ram};
         REG_HAS_CLK: prdata = {31'd0, cfg_ff.has_clock};
         REG_ROM_CNT: prdata = {22'd0, cfg_ff.rom_count};
         REG_MODE_OK: prdata = {31'd0, cfg_ff.mode_ok};
         default:     prdata = 32'd0;
      endcase
   end

   cbc_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_bus_address     (req_bus_address),
      .req_write_data      (req_write_data),
      .req_elapsed_seconds (req_elapsed_seconds),
      .q_valid             (q_valid),
      .q_entry             (q_entry),
      .q_pop               (q_pop)
   );

   cbc_back #(.RAM_BANKS(RAM_BANKS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_valid         (q_valid),
      .q_entry         (q_entry),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_data   (rsp_read_data),
      .rsp_data_source (rsp_data_source),
      .rsp_rom_address (rsp_rom_address)
   );

endmodule

// ----- hw/rtl/cbc_front.sv -----
// Front end: classifies bus words and queues them for the back end.
module cbc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_mode,
   input  logic [15:0]         req_bus_address,
   input  logic [7:0]          req_write_data,
   input  logic [31:0]         req_elapsed_seconds,
   output logic                q_valid,
   output cbc_pkg::entry_type  q_entry,
   input  logic                q_pop
);
   import cbc_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   entry_type  cls;
   logic       push;

   always_comb begin
      cls.addr    = req_bus_address;
      cls.data    = req_write_data;
      cls.elapsed = req_elapsed_seconds;
      cls.op      = OP_NONE;
      if (req_mode) begin
         case (req_bus_address[15:12]) inside
            [4'h0:4'h1]: cls.op = OP_ENABLE;
            [4'h2:4'h3]: cls.op = OP_ROM_BANK;
            [4'h4:4'h5]: cls.op = OP_RAM_BANK;
            [4'h6:4'h7]: cls.op = OP_MODE;
            [4'hA:4'hB]: cls.op = OP_RAM_WRITE;
            default:     cls.op = OP_NONE;
         endcase
      end else begin
         case (req_bus_address[15:12]) inside
            [4'h4:4'h7]: cls.op = OP_ROM_READ;
            [4'hA:4'hB]: cls.op = OP_RAM_READ;
            default:     cls.op = OP_NONE;
         endcase
      end
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_entry   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= cls;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push)  wr_ptr_ff <= !wr_ptr_ff;
         if (q_pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(q_pop);
      end
   end

endmodule

// ----- hw/rtl/cbc_clock.sv -----
// Clock latch unit: reciprocal-multiply division of elapsed seconds into time fields.
module cbc_clock (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [31:0]           elapsed,
   input  logic [5:0]            min_cur,
   input  logic [4:0]            hr_cur,
   input  logic [8:0]            day_cur,
   input  logic                  ovf_cur,
   output logic                  busy,
   output cbc_pkg::clk_upd_type  upd
);
   import cbc_pkg::*;

   typedef enum logic [1:0] {CK_IDLE, CK_QUO, CK_REM, CK_FIN} ck_state_type;

   // x/60 = (x*M60) >> 37 for any 32-bit x; x/24 = (x*M24) >> 25 for x below 2^21
   localparam logic [31:0] M60 = 32'd2290649225;
   localparam logic [31:0] M24 = 32'd1398102;

   ck_state_type state_ff;
   logic [1:0]   phase_ff;
   logic [31:0]  num_ff, quo_ff, quo_in;
   logic [31:0]  mconst, prod_back;
   logic [63:0]  prod;
   logic [5:0]   rem;
   logic [5:0]   r0_ff, r1_ff;
   logic [4:0]   r2_ff;
   logic [6:0]   min_sum;
   logic [5:0]   hr_sum;
   logic [16:0]  total;

   // phases: d/60, then /60 again, then /24; each a quotient state, then a remainder state
   assign mconst    = (phase_ff == 2'd2) ? M24 : M60;
   assign prod      = 64'(num_ff) * 64'(mconst);
   assign quo_in    = (phase_ff == 2'd2) ? prod[56:25] : {5'd0, prod[63:37]};
   assign prod_back = (phase_ff == 2'd2) ?
                      ({quo_ff[26:0], 5'd0} - {quo_ff[28:0], 3'd0}) :
                      ({quo_ff[25:0], 6'd0} - {quo_ff[29:0], 2'd0});
   assign rem       = 6'(num_ff - prod_back);

   always_comb begin
      min_sum = 7'(min_cur) + 7'(r1_ff);
      if (min_sum >= 7'd60) min_sum = min_sum - 7'd60;
      hr_sum = 6'(hr_cur) + 6'(r2_ff);
      if (hr_sum >= 6'd24) hr_sum = hr_sum - 6'd24;
      total = 17'(day_cur) + num_ff[16:0];
      upd.done = (state_ff == CK_FIN);
      upd.sec  = r0_ff;
      upd.min  = min_sum[5:0];
      upd.hr   = hr_sum[4:0];
      upd.day  = total[8:0];
      upd.ovf  = ovf_cur || (total[16:9] != 8'd0);
   end

   assign busy = (state_ff != CK_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CK_IDLE;
         phase_ff <= 2'd0;
      end else begin
         case (state_ff)
            CK_IDLE: begin
               if (start) begin
                  state_ff <= CK_QUO;
                  phase_ff <= 2'd0;
                  num_ff   <= elapsed;
               end
            end
            CK_QUO: begin
               quo_ff   <= quo_in;
               state_ff <= CK_REM;
            end
            CK_REM: begin
               num_ff   <= quo_ff;
               phase_ff <= phase_ff + 2'd1;
               state_ff <= (phase_ff == 2'd2) ? CK_FIN : CK_QUO;
               case (phase_ff)
                  2'd0:    r0_ff <= rem;
                  2'd1:    r1_ff <= rem;
                  default: r2_ff <= rem[4:0];
               endcase
            end
            CK_FIN:  state_ff <= CK_IDLE;
            default: state_ff <= CK_IDLE;
         endcase
      end
   end

endmodule

// ----- hw/rtl/cbc_back.sv -----
// Back end: bank state, external RAM, clock registers and result register.
module cbc_back #(
   parameter int RAM_BANKS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  cbc_pkg::cfg_type    cfg,
   input  logic                q_valid,
   input  cbc_pkg::entry_type  q_entry,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_read_data,
   output logic [1:0]          rsp_data_source,
   output logic [22:0]         rsp_rom_address
);
   import cbc_pkg::*;

   localparam int BW    = (RAM_BANKS > 1) ? $clog2(RAM_BANKS) : 1;
   localparam int DEPTH = RAM_BANKS * RAM_BYTES;
   localparam int AW    = BW + RAM_OFF_W;

   logic [7:0]    mem [DEPTH];
   logic [BW-1:0] mod_tab [16];
   logic [AW-1:0] clr_ptr_ff;
   logic          clr_active_ff;

   logic [8:0]    rom_bank_ff, rom_bank_in;
   logic [BW-1:0] ram_bank_ff, ram_bank_in;
   logic          bank_mode_ff, bank_mode_in;
   logic          ram_en_ff, ram_en_in;
   logic          clk_mapped_ff, clk_mapped_in;
   logic [2:0]    clk_sel_ff, clk_sel_in;
   logic          zero_wr_ff, zero_wr_in;
   logic [5:0]    sec_ff, min_ff;
   logic [4:0]    hr_ff;
   logic [8:0]    day_ff;
   logic          ovf_ff;

   logic          out_valid_ff;
   logic [7:0]    rd_ff, rd_in, mem_q_ff;
   logic          sel_mem_ff, sel_mem_in;
   logic [1:0]    src_ff, src_in;
   logic [22:0]   rom_addr_ff, rom_addr_in;

   logic          out_free, exec, start, clk_busy;
   logic          mem_we;
   logic [AW-1:0] ram_idx, mem_waddr;
   logic [7:0]    clk_data;
   clk_upd_type   upd;

   for (genvar g = 0; g < 16; g++) begin : g_mod
      assign mod_tab[g] = BW'(g % RAM_BANKS);
   end

   assign out_free = !out_valid_ff || !rsp_stall;
   assign exec     = q_valid && out_free && !clr_active_ff && !clk_busy;
   assign q_pop    = exec;
   assign ram_idx  = {ram_bank_ff, q_entry.addr[RAM_OFF_W-1:0]};

   always_comb begin
      case (clk_sel_ff)
         CLK_SEC:  clk_data = {2'b0, sec_ff};
         CLK_MIN:  clk_data = {2'b0, min_ff};
         CLK_HR:   clk_data = {3'b0, hr_ff};
         CLK_DAYL: clk_data = day_ff[7:0];
         CLK_DAYH: clk_data = {ovf_ff, 6'b0, day_ff[8]};
         default:  clk_data = 8'd0;
      endcase
   end

   always_comb begin
      logic [8:0] nb;
      logic       en;
      nb            = rom_bank_ff;
      en            = (q_entry.data[3:0] == 4'hA);
      rom_bank_in   = rom_bank_ff;
      ram_bank_in   = ram_bank_ff;
      bank_mode_in  = bank_mode_ff;
      ram_en_in     = ram_en_ff;
      clk_mapped_in = clk_mapped_ff;
      clk_sel_in    = clk_sel_ff;
      zero_wr_in    = zero_wr_ff;
      start         = 1'b0;
      src_in        = SRC_NONE;
      rd_in         = 8'd0;
      sel_mem_in    = 1'b0;
      rom_addr_in   = '0;
      mem_we        = clr_active_ff;
      if (exec) begin
         case (q_entry.op)
            OP_ENABLE: if (cfg.has_ram) ram_en_in = en;
            OP_ROM_BANK: begin
               case (cfg.version)
                  VER_BANKED: begin
                     nb = {2'b0, rom_bank_ff[6:5], q_entry.data[4:0]};
                     if (q_entry.data[4:0] == 5'd0) nb[0] = 1'b1;
                  end
                  VER_CLOCK: begin
                     nb = {2'b0, q_entry.data[6:0]};
                     if (q_entry.data[6:0] == 7'd0) nb = 9'd1;
                  end
                  VER_WIDE: begin
                     if (q_entry.addr[12] == 1'b0) nb = {rom_bank_ff[8], q_entry.data};
                     else nb = {q_entry.data[0], rom_bank_ff[7:0]};
                  end
                  default: nb = rom_bank_ff;
               endcase
               if (cfg.version != VER_ROM_ONLY) rom_bank_in = clamp_bank(nb, cfg.rom_count);
            end
            OP_RAM_BANK: begin
               case (cfg.version)
                  VER_BANKED: begin
                     if (bank_mode_ff) begin
                        ram_bank_in = mod_tab[{2'b0, q_entry.data[1:0]}];
                     end else begin
                        nb = {2'b0, q_entry.data[1:0], rom_bank_ff[4:0]};
                        if (nb[4:0] == 5'd0 && nb[6:5] != 2'd0) nb[0] = 1'b1;
                        rom_bank_in = clamp_bank(nb, cfg.rom_count);
                     end
                  end
                  VER_CLOCK: begin
                     if (cfg.has_clock && q_entry.data >= 8'h08 && q_entry.data <= 8'h0C) begin
                        clk_mapped_in = 1'b1;
                        clk_sel_in    = 3'(q_entry.data - 8'h08);
                     end else begin
                        clk_mapped_in = 1'b0;
                        ram_bank_in   = mod_tab[{2'b0, q_entry.data[1:0]}];
                     end
                  end
                  VER_WIDE: ram_bank_in = mod_tab[q_entry.data[3:0]];
                  default:  ram_bank_in = ram_bank_ff;
               endcase
            end
            OP_MODE: begin
               if (cfg.version == VER_BANKED) begin
                  if (q_entry.data == 8'd0) bank_mode_in = 1'b0;
                  else if (cfg.mode_ok) bank_mode_in = 1'b1;
               end else if (cfg.version != VER_ROM_ONLY && cfg.has_clock) begin
                  start      = (q_entry.data == 8'd1) && zero_wr_ff;
                  zero_wr_in = (q_entry.data == 8'd0);
               end
            end
            OP_RAM_WRITE: mem_we = cfg.has_ram && ram_en_ff;
            OP_ROM_READ: begin
               src_in = SRC_ROM;
               if (cfg.version == VER_ROM_ONLY)
                  rom_addr_in = {9'd1, q_entry.addr[ROM_OFF_W-1:0]};
               else
                  rom_addr_in = {rom_bank_ff, q_entry.addr[ROM_OFF_W-1:0]};
            end
            OP_RAM_READ: begin
               case (cfg.version)
                  VER_BANKED: begin
                     if (cfg.has_ram && ram_en_ff) begin
                        src_in     = SRC_RAM;
                        sel_mem_in = 1'b1;
                     end
                  end
                  VER_CLOCK: begin
                     if (clk_mapped_ff) begin
                        src_in = SRC_CLOCK;
                        rd_in  = clk_data;
                     end else begin
                        src_in     = SRC_RAM;
                        sel_mem_in = 1'b1;
                     end
                  end
                  VER_WIDE: begin
                     src_in     = SRC_RAM;
                     sel_mem_in = 1'b1;
                  end
                  default: src_in = SRC_NONE;
               endcase
            end
            default: src_in = SRC_NONE;
         endcase
      end
   end

   assign mem_waddr = clr_active_ff ? clr_ptr_ff : ram_idx;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= clr_active_ff ? 8'd0 : q_entry.data;
      if (exec)   mem_q_ff <= mem[ram_idx];
   end

   cbc_clock u_clock (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .elapsed (q_entry.elapsed),
      .min_cur (min_ff),
      .hr_cur  (hr_ff),
      .day_cur (day_ff),
      .ovf_cur (ovf_ff),
      .busy    (clk_busy),
      .upd     (upd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_ptr_ff    <= '0;
         rom_bank_ff   <= 9'd1;
         ram_bank_ff   <= '0;
         bank_mode_ff  <= 1'b0;
         ram_en_ff     <= 1'b0;
         clk_mapped_ff <= 1'b0;
         clk_sel_ff    <= 3'd0;
         zero_wr_ff    <= 1'b0;
         sec_ff        <= 6'd0;
         min_ff        <= 6'd0;
         hr_ff         <= 5'd0;
         day_ff        <= 9'd0;
         ovf_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (clr_active_ff) begin
            if (clr_ptr_ff == AW'(DEPTH - 1)) clr_active_ff <= 1'b0;
            else clr_ptr_ff <= clr_ptr_ff + 1'b1;
         end
         rom_bank_ff   <= rom_bank_in;
         ram_bank_ff   <= ram_bank_in;
         bank_mode_ff  <= bank_mode_in;
         ram_en_ff     <= ram_en_in;
         clk_mapped_ff <= clk_mapped_in;
         clk_sel_ff    <= clk_sel_in;
         zero_wr_ff    <= zero_wr_in;
         if (upd.done) begin
            sec_ff <= upd.sec;
            min_ff <= upd.min;
            hr_ff  <= upd.hr;
            day_ff <= upd.day;
            ovf_ff <= upd.ovf;
         end
         if (out_free) out_valid_ff <= exec;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         rd_ff       <= rd_in;
         sel_mem_ff  <= sel_mem_in;
         src_ff      <= src_in;
         rom_addr_ff <= rom_addr_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_read_data   = sel_mem_ff ? mem_q_ff : rd_ff;
   assign rsp_data_source = src_ff;
   assign rsp_rom_address = rom_addr_ff;

   a_rom_addr_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && src_ff != SRC_ROM |-> rom_addr_ff == '0)
      else $error("rom address set on non-ROM result");
   a_no_result_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !out_valid_ff)
      else $error("result while RAM clear in progress");
   a_latch_ends: assert property (@(posedge clock) disable iff (reset)
      upd.done |=> !clk_busy)
      else $error("clock unit busy after update");

endmodule
